FILE: src/adcp_pkg.sv
// ----------------------------------------------------------------------------
// adcp_pkg
// Shared constants for the audio DSP command port: port offsets, command
// bytes, reply codes, parser phases and mixer store geometry.
// ----------------------------------------------------------------------------
`default_nettype none

package adcp_pkg;

	// Mixer store geometry
	localparam int MIXER_ENTRIES = 256;
	localparam int MIX_AW        = $clog2(MIXER_ENTRIES);

	// Access kinds
	localparam logic OP_READ  = 1'b0;
	localparam logic OP_WRITE = 1'b1;

	// Port offsets from base
	localparam logic [3:0] OFS_MIX_INDEX = 4'h4;
	localparam logic [3:0] OFS_MIX_DATA  = 4'h5;
	localparam logic [3:0] OFS_RESET     = 4'h6;
	localparam logic [3:0] OFS_READ      = 4'hA;
	localparam logic [3:0] OFS_WRITE     = 4'hC;
	localparam logic [3:0] OFS_STATUS    = 4'hE;

	// Reply and status bytes
	localparam logic [7:0] REPLY_BYTE   = 8'hAA;
	localparam logic [7:0] STATUS_READY = 8'h80;

	// Command bytes
	localparam logic [7:0] CMD_RATE    = 8'h41;
	localparam logic [7:0] CMD_PLAY    = 8'h14;
	localparam logic [7:0] CMD_HALT    = 8'hD0;
	localparam logic [7:0] CMD_SPK_ON  = 8'hD1;
	localparam logic [7:0] CMD_SPK_OFF = 8'hD3;

	// Command parser phases
	localparam logic [2:0] PH_IDLE    = 3'd0;
	localparam logic [2:0] PH_RATE_HI = 3'd1;
	localparam logic [2:0] PH_RATE_LO = 3'd2;
	localparam logic [2:0] PH_LEN_LO  = 3'd3;
	localparam logic [2:0] PH_LEN_HI  = 3'd4;

	// One result item as it sits in the pipeline
	typedef struct packed {
		logic [7:0]  read_data;
		logic [15:0] rate_hz;
		logic [15:0] block_length;
		logic        speaker_enabled;
		logic        playback_active;
	} res_t;

endpackage

`default_nettype wire

FILE: src/audio_dsp_command_port_core.sv
// ----------------------------------------------------------------------------
// audio_dsp_command_port_core
// Device side of the DSP port window: reset handshake, command parser for
// rate/playback/halt/speaker commands, and the mixer index latch and store.
//
//   channel | signals                               | direction
//   --------+---------------------------------------+----------
//   in      | in_valid in_ready opcode port_offset  | to core
//           | write_data                            |
//   out     | out_valid out_ready read_data rate_hz | from core
//           | block_length                          |
//           | speaker_enabled playback_active       |
//
// One item per cycle sustained while the output is not stalled; an accepted
// item loads s1 and then the output register before its result is offered.
// The s1 stage holds the registered mixer read, so its latency is set by that
// memory read port. Reset clears all control state and the 256 mixer valid
// bits at once; no clearing pass is needed. A stalled output holds its item
// while s1 can still take one more, so input stalls only when both are full.
// ----------------------------------------------------------------------------
`default_nettype none

module audio_dsp_command_port_core (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        in_valid,
	output logic             in_ready,
	input  wire logic        opcode,
	input  wire logic [3:0]  port_offset,
	input  wire logic [7:0]  write_data,
	output logic             out_valid,
	input  wire logic        out_ready,
	output logic [7:0]       read_data,
	output logic [15:0]      rate_hz,
	output logic [15:0]      block_length,
	output logic             speaker_enabled,
	output logic             playback_active
);

	localparam int ENT = adcp_pkg::MIXER_ENTRIES;
	localparam int AW  = adcp_pkg::MIX_AW;

	// Architectural state
	logic          rst_asserted_q, rst_asserted_d;
	logic          reply_pend_q, reply_pend_d;
	logic [2:0]    phase_q, phase_d;
	logic [15:0]   rate_q, rate_d;
	logic [15:0]   len_q, len_d;
	logic          spk_q, spk_d;
	logic          dma_q, dma_d;
	logic [7:0]    mix_idx_q, mix_idx_d;
	logic [ENT-1:0] mix_vld_q;
	logic [7:0]    mix_mem [ENT];

	// Pipeline
	logic          valid_s1;
	adcp_pkg::res_t res_s1;
	logic          mix_hit_s1;
	logic [7:0]    mix_rd_s1;
	logic          out_valid_q;
	adcp_pkg::res_t out_q;

	logic          acc, adv;
	logic          in_range, mix_we, rd_mix;
	logic [AW-1:0] mix_addr;
	logic [7:0]    rd_byte;
	adcp_pkg::res_t res_s1_res;

	// Handshake
	assign acc      = in_valid && in_ready;
	assign adv      = valid_s1 && (!out_valid_q || out_ready);
	assign in_ready = !valid_s1 || !out_valid_q || out_ready;

	assign in_range = (9'(mix_idx_q) < 9'(ENT));
	assign mix_addr = mix_idx_q[AW-1:0];

	// Next state for one access
	always_comb begin
		rst_asserted_d = rst_asserted_q;
		reply_pend_d   = reply_pend_q;
		phase_d        = phase_q;
		rate_d         = rate_q;
		len_d          = len_q;
		spk_d          = spk_q;
		dma_d          = dma_q;
		mix_idx_d      = mix_idx_q;
		mix_we         = 1'b0;
		rd_mix         = 1'b0;
		rd_byte        = 8'h00;
		if (opcode == adcp_pkg::OP_WRITE) begin
			case (port_offset)
				adcp_pkg::OFS_MIX_INDEX: begin
					mix_idx_d = write_data;
				end
				adcp_pkg::OFS_MIX_DATA: begin
					mix_we = in_range;
				end
				adcp_pkg::OFS_RESET: begin
					// 1 then 0 completes the reset handshake
					if (write_data[0]) begin
						rst_asserted_d = 1'b1;
					end else if (rst_asserted_q) begin
						rst_asserted_d = 1'b0;
						phase_d        = adcp_pkg::PH_IDLE;
						spk_d          = 1'b0;
						dma_d          = 1'b0;
						reply_pend_d   = 1'b1;
					end
				end
				adcp_pkg::OFS_WRITE: begin
					case (phase_q)
						adcp_pkg::PH_RATE_HI: begin
							rate_d  = {write_data, rate_q[7:0]};
							phase_d = adcp_pkg::PH_RATE_LO;
						end
						adcp_pkg::PH_RATE_LO: begin
							rate_d  = {rate_q[15:8], write_data};
							phase_d = adcp_pkg::PH_IDLE;
						end
						adcp_pkg::PH_LEN_LO: begin
							len_d   = {len_q[15:8], write_data};
							phase_d = adcp_pkg::PH_LEN_HI;
						end
						adcp_pkg::PH_LEN_HI: begin
							len_d   = {write_data, len_q[7:0]};
							phase_d = adcp_pkg::PH_IDLE;
							dma_d   = 1'b1;
						end
						default: begin
							// idle, and any stray phase code, decodes a command
							phase_d = adcp_pkg::PH_IDLE;
							case (write_data)
								adcp_pkg::CMD_RATE:    phase_d = adcp_pkg::PH_RATE_HI;
								adcp_pkg::CMD_PLAY:    phase_d = adcp_pkg::PH_LEN_LO;
								adcp_pkg::CMD_HALT:    dma_d   = 1'b0;
								adcp_pkg::CMD_SPK_ON:  spk_d   = 1'b1;
								adcp_pkg::CMD_SPK_OFF: spk_d   = 1'b0;
								default: ;
							endcase
						end
					endcase
				end
				default: ;
			endcase
		end else begin
			case (port_offset)
				adcp_pkg::OFS_MIX_INDEX: rd_byte = mix_idx_q;
				adcp_pkg::OFS_MIX_DATA:  rd_mix  = in_range;
				adcp_pkg::OFS_STATUS: begin
					rd_byte = reply_pend_q ? adcp_pkg::STATUS_READY : 8'h00;
				end
				adcp_pkg::OFS_READ: begin
					if (reply_pend_q) begin
						rd_byte      = adcp_pkg::REPLY_BYTE;
						reply_pend_d = 1'b0;
					end
				end
				default: ;
			endcase
		end
	end

	// State registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rst_asserted_q <= 1'b0;
			reply_pend_q   <= 1'b0;
			phase_q        <= adcp_pkg::PH_IDLE;
			rate_q         <= 16'h0000;
			len_q          <= 16'h0000;
			spk_q          <= 1'b0;
			dma_q          <= 1'b0;
			mix_idx_q      <= 8'h00;
			mix_vld_q      <= '0;
		end else if (acc) begin
			rst_asserted_q <= rst_asserted_d;
			reply_pend_q   <= reply_pend_d;
			phase_q        <= phase_d;
			rate_q         <= rate_d;
			len_q          <= len_d;
			spk_q          <= spk_d;
			dma_q          <= dma_d;
			mix_idx_q      <= mix_idx_d;
			if (mix_we) begin
				mix_vld_q[mix_addr] <= 1'b1;
			end
		end
	end

	// Mixer store: at most one write and one registered read per cycle, on an accepted access
	always_ff @(posedge clk) begin
		if (acc && mix_we) begin
			mix_mem[mix_addr] <= write_data;
		end
		if (acc) begin
			mix_rd_s1 <= mix_mem[mix_addr];
		end
	end

	// s1 stage payload
	always_ff @(posedge clk) begin
		if (acc) begin
			res_s1.read_data       <= rd_byte;
			res_s1.rate_hz         <= rate_d;
			res_s1.block_length    <= len_d;
			res_s1.speaker_enabled <= spk_d;
			res_s1.playback_active <= dma_d;
			mix_hit_s1             <= rd_mix && mix_vld_q[mix_addr];
		end
	end

	// Unwritten mixer entries read as zero
	always_comb begin
		res_s1_res = res_s1;
		if (mix_hit_s1) begin
			res_s1_res.read_data = mix_rd_s1;
		end
	end

	// Valid flags
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1    <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (acc) begin
				valid_s1 <= 1'b1;
			end else if (adv) begin
				valid_s1 <= 1'b0;
			end
			if (adv) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// Output register
	always_ff @(posedge clk) begin
		if (adv) begin
			out_q <= res_s1_res;
		end
	end

	assign out_valid       = out_valid_q;
	assign read_data       = out_q.read_data;
	assign rate_hz         = out_q.rate_hz;
	assign block_length    = out_q.block_length;
	assign speaker_enabled = out_q.speaker_enabled;
	assign playback_active = out_q.playback_active;

endmodule

`default_nettype wire

FILE: src/adcp_checker.sv
// ----------------------------------------------------------------------------
// adcp_checker
// Port-level checks for the audio DSP command port core, bound to the top.
// ----------------------------------------------------------------------------
`default_nettype none

module adcp_checker (
	input wire logic        clk,
	input wire logic        arst_n,
	input wire logic        in_valid,
	input wire logic        in_ready,
	input wire logic        opcode,
	input wire logic [3:0]  port_offset,
	input wire logic [7:0]  write_data,
	input wire logic        out_valid,
	input wire logic        out_ready,
	input wire logic [7:0]  read_data,
	input wire logic [15:0] rate_hz,
	input wire logic [15:0] block_length,
	input wire logic        speaker_enabled,
	input wire logic        playback_active
);

	// A waiting item stays offered with its payload
	a_in_hold: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && !in_ready |=> in_valid && $stable(opcode) && $stable(port_offset)
			&& $stable(write_data))
		else $error("input item changed while waiting");

	// A stalled result stays offered
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid)
		else $error("result dropped while stalled");

	// A stalled result keeps its payload
	a_out_stable: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> $stable(read_data) && $stable(rate_hz)
			&& $stable(block_length) && $stable(speaker_enabled)
			&& $stable(playback_active))
		else $error("stalled result payload changed");

	// Input backs up only when both result slots are full and stalled
	a_in_stall: assert property (@(posedge clk) disable iff (!arst_n)
		!in_ready |-> out_valid && !out_ready)
		else $error("input stalled with room downstream");

	// A fresh result appears only after its item has passed s1 and the output register
	a_latency: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid) |-> $past(in_valid && in_ready, 2))
		else $error("result without a matching item");

endmodule

bind audio_dsp_command_port_core adcp_checker u_adcp_checker (.*);

`default_nettype wire
